// ===== rtl/stkr_pkg.sv =====
// Shared types and codes for the sorted top-k result table.
`default_nettype none

package stkr_pkg;

  // Item kinds
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_INSERT = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // Result status codes
  localparam logic [2:0] STAT_DONE     = 3'd0;
  localparam logic [2:0] STAT_INSERTED = 3'd1;
  localparam logic [2:0] STAT_UPDATED  = 3'd2;
  localparam logic [2:0] STAT_DUP_KEPT = 3'd3;
  localparam logic [2:0] STAT_REJECTED = 3'd4;

  typedef struct packed {
    logic [1:0]         kind;
    logic [31:0]        node_key;
    logic signed [31:0] relevance_in;
    logic signed [31:0] similarity_in;
    logic signed [31:0] weight_in;
    logic [4:0]         hops_in;
    logic [3:0]         read_index;
  } in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic               entry_valid;
    logic [31:0]        node_out;
    logic signed [31:0] relevance_out;
    logic signed [31:0] similarity_out;
    logic signed [31:0] weight_out;
    logic [4:0]         hops_out;
    logic [4:0]         entry_count;
  } out_t;

  // One stored table row
  typedef struct packed {
    logic [31:0]        node;
    logic signed [31:0] rel;
    logic signed [31:0] sim;
    logic signed [31:0] wt;
    logic [4:0]         hops;
  } entry_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic node_eq;
    logic rel_gt;
  } cmp_t;

endpackage

`default_nettype wire

// ===== rtl/sorted_top_k_result_table_unit.sv =====
// Top level of the sorted top-k result table with duplicate suppression.
//
//   channel   ports                     handshake
//   -------   -----------------------   ----------------------------------
//   command   start, busy, item_i       beat taken when start && !busy
//   result    done_o, result_o          one-cycle strobe, cannot stall
//
// Clear and unused kinds finish at once: the result beat shows in the next
// cycle and busy never rises. A read holds busy only in S_READ (one registered
// read of the table memory). An insert walks the table through the single
// memory read port, one row a cycle, then moves the rows below the insert
// point down one place, again one row a cycle. Busy stays high through the
// walk and the moves; the walk ends early at the row where the id is found.
// For a read or an insert, the result beat shows in the same cycle busy falls.
// Reset clears the count and the sequencer only; the table rows are never
// shown before written since reads past the count return zeros.
`default_nettype none

module sorted_top_k_result_table_unit import stkr_pkg::*; #(
  parameter int TABLE_DEPTH = 16,
  parameter int HOP_LIMIT   = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  in_t  item_i,
  output logic done_o,
  output out_t result_o
);

  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int WideW = (CntW > 4) ? CntW : 4;
  localparam logic [CntW-1:0] FullCnt = CntW'(TABLE_DEPTH);
  localparam logic [CntW-1:0] LastRow = CntW'(TABLE_DEPTH - 1);
  localparam logic [7:0]      HopLim  = 8'(HOP_LIMIT);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_READ  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_SHIFT = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] issue_q, issue_d;     // next row to fetch during the walk
  logic            pend_q, pend_d;       // fetched row waits in rd_q
  logic [IdxW-1:0] pend_idx_q, pend_idx_d;
  logic            found_q, found_d;     // insert point already seen
  logic [CntW-1:0] pos_q, pos_d;
  logic [CntW-1:0] src_q, src_d;         // shift: destination of next move
  logic            wr_pend_q, wr_pend_d;
  logic [IdxW-1:0] wr_idx_q, wr_idx_d;
  entry_t          ins_q, ins_d;
  logic [3:0]      rdidx_q, rdidx_d;
  logic            done_q, done_d;
  out_t            res_q, res_d;

  // Table memory: one write port, one registered read port
  entry_t          mem_q [TABLE_DEPTH];
  entry_t          rd_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic [IdxW-1:0] mem_raddr;

  logic [CntW-1:0] src_m1;
  logic [4:0]      hops_sat;
  cmp_t            cmp;

  assign src_m1 = src_q - CntW'(1);
  assign hops_sat = (8'(item_i.hops_in) > HopLim) ? 5'(HOP_LIMIT) : item_i.hops_in;

  stkr_cmp u_cmp (
    .new_node_i (ins_q.node),
    .new_rel_i  (ins_q.rel),
    .ent_node_i (rd_q.node),
    .ent_rel_i  (rd_q.rel),
    .cmp_o      (cmp)
  );

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem_q[mem_raddr];
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    pend_idx_d = pend_idx_q;
    found_d    = found_q;
    pos_d      = pos_q;
    src_d      = src_q;
    wr_pend_d  = 1'b0;
    wr_idx_d   = wr_idx_q;
    ins_d      = ins_q;
    rdidx_d    = rdidx_q;
    done_d     = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = pend_idx_q;
    mem_wdata  = ins_q;
    mem_raddr  = issue_q[IdxW-1:0];

    case (state_q)
      S_IDLE: begin
        mem_raddr = IdxW'(item_i.read_index);
        if (start) begin
          ins_d.node = item_i.node_key;
          ins_d.rel  = item_i.relevance_in;
          ins_d.sim  = item_i.similarity_in;
          ins_d.wt   = item_i.weight_in;
          ins_d.hops = hops_sat;
          rdidx_d    = item_i.read_index;
          case (item_i.kind)
            KIND_CLEAR: begin
              cnt_d  = '0;
              done_d = 1'b1;
              res_d  = '0;
            end
            KIND_INSERT: begin
              issue_d = '0;
              found_d = 1'b0;
              pos_d   = cnt_q;
              state_d = S_SCAN;
            end
            KIND_READ: begin
              state_d = S_READ;
            end
            default: begin
              // unused kind: report done, touch nothing
              done_d = 1'b1;
              res_d  = '0;
            end
          endcase
        end
      end

      S_READ: begin
        done_d = 1'b1;
        res_d  = '0;
        if (WideW'(rdidx_q) < WideW'(cnt_q)) begin
          res_d.entry_valid    = 1'b1;
          res_d.node_out       = rd_q.node;
          res_d.relevance_out  = rd_q.rel;
          res_d.similarity_out = rd_q.sim;
          res_d.weight_out     = rd_q.wt;
          res_d.hops_out       = rd_q.hops;
        end
        state_d = S_IDLE;
      end

      S_SCAN: begin
        // fetch one row a cycle, check the row fetched last cycle
        if (issue_q < cnt_q) begin
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IdxW-1:0];
          issue_d    = issue_q + CntW'(1);
        end
        if (pend_q && cmp.node_eq) begin
          done_d  = 1'b1;
          res_d   = '0;
          pend_d  = 1'b0;
          state_d = S_IDLE;
          if (cmp.rel_gt) begin
            // rewrite in place, keep position
            mem_we       = 1'b1;
            mem_waddr    = pend_idx_q;
            res_d.status = STAT_UPDATED;
          end else begin
            res_d.status = STAT_DUP_KEPT;
          end
        end else if (pend_q) begin
          if (!found_q && cmp.rel_gt) begin
            found_d = 1'b1;
            pos_d   = CntW'(pend_idx_q);
          end
        end else if (!(issue_q < cnt_q)) begin
          if (cnt_q != FullCnt) begin
            cnt_d   = cnt_q + CntW'(1);
            src_d   = cnt_q;
            state_d = S_SHIFT;
          end else if (found_q) begin
            // full: drop the last row
            src_d   = LastRow;
            state_d = S_SHIFT;
          end else begin
            done_d       = 1'b1;
            res_d        = '0;
            res_d.status = STAT_REJECTED;
            state_d      = S_IDLE;
          end
        end
      end

      S_SHIFT: begin
        // read row src-1, write it to row src in the next cycle
        mem_raddr = src_m1[IdxW-1:0];
        if (src_q > pos_q) begin
          wr_pend_d = 1'b1;
          wr_idx_d  = src_q[IdxW-1:0];
          src_d     = src_m1;
        end
        if (wr_pend_q) begin
          mem_we    = 1'b1;
          mem_waddr = wr_idx_q;
          mem_wdata = rd_q;
        end else if (!(src_q > pos_q)) begin
          mem_we       = 1'b1;
          mem_waddr    = pos_q[IdxW-1:0];
          mem_wdata    = ins_q;
          done_d       = 1'b1;
          res_d        = '0;
          res_d.status = STAT_INSERTED;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done_d) begin
      res_d.entry_count = 5'(cnt_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      issue_q   <= '0;
      pend_q    <= 1'b0;
      found_q   <= 1'b0;
      pos_q     <= '0;
      src_q     <= '0;
      wr_pend_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      issue_q   <= issue_d;
      pend_q    <= pend_d;
      found_q   <= found_d;
      pos_q     <= pos_d;
      src_q     <= src_d;
      wr_pend_q <= wr_pend_d;
      done_q    <= done_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    wr_idx_q   <= wr_idx_d;
    ins_q      <= ins_d;
    rdidx_q    <= rdidx_d;
    res_q      <= res_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

`default_nettype wire

// ===== rtl/stkr_cmp.sv =====
// Shared compare unit: node id match and signed relevance order.
`default_nettype none

module stkr_cmp import stkr_pkg::*; (
  input  logic [31:0]        new_node_i,
  input  logic signed [31:0] new_rel_i,
  input  logic [31:0]        ent_node_i,
  input  logic signed [31:0] ent_rel_i,
  output cmp_t               cmp_o
);

  assign cmp_o.node_eq = (new_node_i == ent_node_i);
  assign cmp_o.rel_gt  = (new_rel_i > ent_rel_i);

endmodule

`default_nettype wire

// ===== rtl/stkr_chk.sv =====
// Port-level checker for the sorted top-k result table, bound to the top level.
`default_nettype none

module stkr_chk import stkr_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start,
  input wire logic busy,
  input wire in_t  item_i,
  input wire logic done_o,
  input wire out_t result_o
);

  // clear finishes at once and empties the table
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_CLEAR) |=>
      (done_o && result_o.entry_count == 5'd0 && !busy))
    else $error("clear beat did not empty the table in one cycle");

  // read raises busy and then gives its beat
  a_read_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && item_i.kind == KIND_READ) |=> busy ##1 done_o)
    else $error("read beat not delivered on time");

  // only a read can show a valid entry
  a_valid_only_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.entry_valid) |-> (result_o.status == STAT_DONE))
    else $error("entry shown on a non-read result");

  // a successful insert leaves at least one entry
  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status == STAT_INSERTED || result_o.status == STAT_UPDATED))
      |-> (result_o.entry_count != 5'd0))
    else $error("insert reported with an empty table");

endmodule

bind sorted_top_k_result_table_unit stkr_chk u_stkr_chk (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .item_i   (item_i),
  .done_o   (done_o),
  .result_o (result_o)
);

`default_nettype wire
